FILE: src/hafr_pkg.sv
package hafr_pkg;

  localparam logic [7:0]  FLAG_BYTE    = 8'h7E;
  localparam logic [7:0]  ESC_BYTE     = 8'h7D;
  localparam logic [7:0]  ESC_XOR      = 8'h20;
  localparam logic [15:0] CHECK_INIT   = 16'hFFFF;
  localparam logic [15:0] CHECK_GOOD   = 16'hF0B8;
  localparam logic [15:0] CHECK_POLY   = 16'h8408;
  localparam int          HEADER_BYTES = 6;
  localparam logic [11:0] LEN_MAX      = 12'hFFF;

  // configuration register indexes
  localparam logic CFG_ADDRESS = 1'b0;
  localparam logic CFG_CONTROL = 1'b1;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_END     = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_GOOD       = 3'd0,
    ST_BAD_CHECK  = 3'd1,
    ST_TOO_SHORT  = 3'd2,
    ST_BAD_HEADER = 3'd3,
    ST_OVERFLOW   = 3'd4
  } frame_status_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    kind_t         kind;
    logic [7:0]    payload_byte;
    logic [15:0]   protocol_id;
    frame_status_t frame_status;
    logic [11:0]   payload_length;
  } result_t;

  // reflected CRC-16 update over one byte, LSB first
  function automatic logic [15:0] check_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CHECK_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: src/hafr_in_reg.sv
module hafr_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,
  input  logic              adv,
  output hafr_pkg::item_t   item
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;

  // take a new item whenever the register is empty or the held one is consumed this cycle
  assign in_tready = !valid_r || adv;
  assign valid_nxt = in_tvalid ? 1'b1 : (adv ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
    end
  end

  assign item.valid   = valid_r;
  assign item.rx_byte = byte_r;

endmodule

FILE: src/hafr_core.sv
module hafr_core #(
  parameter int MAX_FRAME_BYTES = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  hafr_pkg::item_t   item,
  output logic              adv,
  input  logic              cfg_we,
  input  logic              cfg_addr,
  input  logic [7:0]        cfg_data,
  output logic              res_valid,
  input  logic              res_ready,
  output hafr_pkg::result_t res
);

  localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int LW = (CW > 13) ? CW : 13;

  logic [7:0]        exp_addr_r, exp_ctrl_r;
  logic              esc_r, esc_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              hdr_ok_r, hdr_ok_nxt;
  logic [15:0]       proto_r, proto_nxt;
  logic [7:0]        dl0_r, dl0_nxt, dl1_r, dl1_nxt;
  logic              out_valid_r, out_valid_nxt;
  hafr_pkg::result_t out_r, out_nxt;

  logic              fire;
  logic              emit;
  logic [7:0]        bx;
  logic [LW-1:0]     cnt_ext;
  logic [LW-1:0]     len_wide;
  logic [11:0]       len;
  hafr_pkg::frame_status_t end_status;

  assign adv  = !out_valid_r || res_ready;
  assign fire = item.valid && adv;

  // payload length for an end result, saturated to the field
  assign cnt_ext  = LW'(cnt_r);
  assign len_wide = cnt_ext - LW'(hafr_pkg::HEADER_BYTES);
  always_comb begin
    if (cnt_ext < LW'(hafr_pkg::HEADER_BYTES)) begin
      len = '0;
    end else if (len_wide > LW'(hafr_pkg::LEN_MAX)) begin
      len = hafr_pkg::LEN_MAX;
    end else begin
      len = len_wide[11:0];
    end
  end

  always_comb begin
    if (crc_r != hafr_pkg::CHECK_GOOD) begin
      end_status = hafr_pkg::ST_BAD_CHECK;
    end else if (cnt_r < CW'(hafr_pkg::HEADER_BYTES)) begin
      end_status = hafr_pkg::ST_TOO_SHORT;
    end else if (!hdr_ok_r) begin
      end_status = hafr_pkg::ST_BAD_HEADER;
    end else begin
      end_status = hafr_pkg::ST_GOOD;
    end
  end

  always_comb begin
    esc_nxt    = esc_r;
    crc_nxt    = crc_r;
    cnt_nxt    = cnt_r;
    hdr_ok_nxt = hdr_ok_r;
    proto_nxt  = proto_r;
    dl0_nxt    = dl0_r;
    dl1_nxt    = dl1_r;
    emit       = 1'b0;
    bx         = item.rx_byte ^ (esc_r ? hafr_pkg::ESC_XOR : 8'h00);
    out_nxt.kind           = hafr_pkg::KIND_END;
    out_nxt.payload_byte   = '0;
    out_nxt.protocol_id    = proto_r;
    out_nxt.frame_status   = end_status;
    out_nxt.payload_length = len;

    if (item.rx_byte == hafr_pkg::FLAG_BYTE) begin
      esc_nxt = 1'b0;
      emit    = (cnt_r != '0);
    end else if (item.rx_byte == hafr_pkg::ESC_BYTE) begin
      esc_nxt = 1'b1;
    end else if (cnt_r == CW'(MAX_FRAME_BYTES)) begin
      // drop the byte and close the frame as overflowed
      esc_nxt              = 1'b0;
      emit                 = 1'b1;
      out_nxt.frame_status = hafr_pkg::ST_OVERFLOW;
    end else begin
      esc_nxt = 1'b0;
      crc_nxt = hafr_pkg::check_update(crc_r, bx);
      if (cnt_r == CW'(0)) begin
        hdr_ok_nxt = (bx == exp_addr_r);
      end else if (cnt_r == CW'(1)) begin
        hdr_ok_nxt = hdr_ok_r && (bx == exp_ctrl_r);
      end else if (cnt_r == CW'(2)) begin
        proto_nxt = {bx, 8'h00};
      end else if (cnt_r == CW'(3)) begin
        proto_nxt = {proto_r[15:8], bx};
      end
      if (cnt_r >= CW'(hafr_pkg::HEADER_BYTES)) begin
        emit                   = 1'b1;
        out_nxt.kind           = hafr_pkg::KIND_PAYLOAD;
        out_nxt.payload_byte   = dl0_r;
        out_nxt.protocol_id    = '0;
        out_nxt.frame_status   = hafr_pkg::ST_GOOD;
        out_nxt.payload_length = '0;
      end
      dl0_nxt = dl1_r;
      dl1_nxt = bx;
      cnt_nxt = cnt_r + CW'(1);
    end

    // restart the frame on a flag or an overflow
    if (item.rx_byte == hafr_pkg::FLAG_BYTE ||
        (item.rx_byte != hafr_pkg::ESC_BYTE && cnt_r == CW'(MAX_FRAME_BYTES))) begin
      crc_nxt    = hafr_pkg::CHECK_INIT;
      cnt_nxt    = '0;
      hdr_ok_nxt = 1'b0;
      proto_nxt  = '0;
      dl0_nxt    = '0;
      dl1_nxt    = '0;
    end
  end

  assign out_valid_nxt = fire ? emit : (res_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_addr_r  <= 8'hFF;
      exp_ctrl_r  <= 8'h03;
      esc_r       <= 1'b0;
      crc_r       <= hafr_pkg::CHECK_INIT;
      cnt_r       <= '0;
      hdr_ok_r    <= 1'b0;
      proto_r     <= '0;
      dl0_r       <= '0;
      dl1_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          hafr_pkg::CFG_ADDRESS: exp_addr_r <= cfg_data;
          hafr_pkg::CFG_CONTROL: exp_ctrl_r <= cfg_data;
          default: ;
        endcase
      end
      if (fire) begin
        esc_r    <= esc_nxt;
        crc_r    <= crc_nxt;
        cnt_r    <= cnt_nxt;
        hdr_ok_r <= hdr_ok_nxt;
        proto_r  <= proto_nxt;
        dl0_r    <= dl0_nxt;
        dl1_r    <= dl1_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_r <= out_nxt;
    end
  end

  assign res_valid = out_valid_r;
  assign res       = out_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_FRAME_BYTES))
    else $error("frame byte count beyond maximum");

  a_flag_restart: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.rx_byte == hafr_pkg::FLAG_BYTE |=> cnt_r == '0 && !esc_r &&
    crc_r == hafr_pkg::CHECK_INIT)
    else $error("flag did not restart the frame");

  a_esc_pending: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.rx_byte == hafr_pkg::ESC_BYTE |=> esc_r && $stable(cnt_r))
    else $error("escape did not set pending state");

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.kind == hafr_pkg::KIND_PAYLOAD |->
    out_r.frame_status == hafr_pkg::ST_GOOD && out_r.payload_length == '0)
    else $error("payload result carries end fields");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_ready |=> $stable(out_r) && out_valid_r)
    else $error("pending result overwritten");

endmodule

FILE: src/hdlc_async_frame_receiver.sv
// HDLC-style asynchronous frame receiver (PPP octet deframer, FCS-16 check).
// Input stream: one raw line byte per item on in_tdata. Flag bytes close a
// frame, escape bytes unescape the next byte; the reflected CRC-16 runs over
// the unescaped bytes.
// Output stream: out_tuser is the kind (0 payload byte, 1 end of frame);
// out_tdata carries payload byte, protocol id, status and payload length.
// Payload bytes lag the line by two data bytes so the check bytes are never
// sent; an end item follows a closing flag of a non-empty frame, or an
// overflowing byte.
// Configuration: cfg_we writes cfg_data to register cfg_addr (0 expected
// address, 1 expected control) at any edge; write only while idle.
// Path: an accepted input item passes through the input register, then the
// deframer logic into the result register, which drives out_tvalid.
// Throughput: one item per cycle while no result is held back by out_tready;
// the CRC and escape update is combinational between the two registers.
// Reset (rst_n low, synchronous) clears both stages and the frame state and
// loads the expected address 0xFF and control 0x03.
// When out_tready is low, a pending result holds, one more input item is
// taken into the input register, and then in_tready drops.
module hdlc_async_frame_receiver #(
  parameter int MAX_FRAME_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] payload_byte, [23:8] protocol_id,
                                  // [26:24] frame_status, [38:27] payload_length
  output logic        out_tuser,  // [0] kind
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_data
);

  hafr_pkg::item_t   item;
  hafr_pkg::result_t res;
  logic              adv;

  hafr_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .adv       (adv),
    .item      (item)
  );

  hafr_core #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (item),
    .adv       (adv),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {1'b0, res.payload_length, res.frame_status, res.protocol_id,
                      res.payload_byte};
  assign out_tuser = res.kind;

endmodule

FILE: tb/sv/hdlc_async_frame_receiver_test.sv
module hdlc_async_frame_receiver_test;

  localparam int MAX_BYTES      = 4096;
  localparam int SETTLE_CYCLES  = 8;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int REPORT_LIMIT   = 10;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tuser;
  logic        cfg_we     = 1'b0;
  logic        cfg_addr   = hafr_pkg::CFG_ADDRESS;
  logic [7:0]  cfg_data   = 8'h00;

  hdlc_async_frame_receiver #(.MAX_FRAME_BYTES(MAX_BYTES)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // deframer state as the block should hold it
  logic [7:0]  want_address = 8'hFF;
  logic [7:0]  want_control = 8'h03;
  logic        esc_seen     = 1'b0;
  logic [15:0] fcs_acc      = hafr_pkg::CHECK_INIT;
  int          frame_len    = 0;
  logic        hdr_match    = 1'b0;
  logic [15:0] proto_acc    = 16'h0000;
  logic [7:0]  lag [2]      = '{8'h00, 8'h00};

  hafr_pkg::result_t expected_results[$];
  logic [7:0]        line_q[$];
  logic [7:0]        frame_body[$];

  int send_idle_pct = 20;
  int recv_idle_pct = 79;
  int fail_count    = 0;
  int got_count     = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;
  int idle_cycles   = 0;
  hafr_pkg::result_t oldest_result;

  task automatic add_line(input logic [7:0] b);
    line_q.insert(line_q.size(), b);
  endtask

  task automatic add_body(input logic [7:0] b);
    frame_body.insert(frame_body.size(), b);
  endtask

  task automatic add_expect(input hafr_pkg::result_t r);
    expected_results.insert(expected_results.size(), r);
  endtask

  // bit-serial form of the reflected FCS-16
  function automatic logic [15:0] fcs16_next(input logic [15:0] fcs, input logic [7:0] data);
    logic [15:0] acc;
    logic        fb;
    acc = fcs;
    for (int i = 0; i < 8; i++) begin
      fb  = acc[0] ^ data[i];
      acc = acc >> 1;
      if (fb) acc = acc ^ hafr_pkg::CHECK_POLY;
    end
    return acc;
  endfunction

  task automatic restart_frame();
    fcs_acc   = hafr_pkg::CHECK_INIT;
    frame_len = 0;
    hdr_match = 1'b0;
    proto_acc = 16'h0000;
    lag[0]    = 8'h00;
    lag[1]    = 8'h00;
  endtask

  task automatic push_end(input hafr_pkg::frame_status_t status);
    hafr_pkg::result_t r;
    int                len;
    len = (frame_len >= hafr_pkg::HEADER_BYTES) ? frame_len - hafr_pkg::HEADER_BYTES : 0;
    if (len > 4095) len = 4095;
    r.kind           = hafr_pkg::KIND_END;
    r.payload_byte   = 8'h00;
    r.protocol_id    = proto_acc;
    r.frame_status   = status;
    r.payload_length = len[11:0];
    add_expect(r);
  endtask

  task automatic deframe_byte(input logic [7:0] line_byte);
    logic [7:0]        b;
    hafr_pkg::result_t r;
    b = line_byte;
    if (b == hafr_pkg::FLAG_BYTE) begin
      esc_seen = 1'b0;
      if (frame_len != 0) begin
        if (fcs_acc != hafr_pkg::CHECK_GOOD) push_end(hafr_pkg::ST_BAD_CHECK);
        else if (frame_len < hafr_pkg::HEADER_BYTES) push_end(hafr_pkg::ST_TOO_SHORT);
        else if (!hdr_match) push_end(hafr_pkg::ST_BAD_HEADER);
        else push_end(hafr_pkg::ST_GOOD);
      end
      restart_frame();
    end else if (b == hafr_pkg::ESC_BYTE) begin
      esc_seen = 1'b1;
    end else begin
      if (esc_seen) begin
        b        = b ^ hafr_pkg::ESC_XOR;
        esc_seen = 1'b0;
      end
      if (frame_len >= MAX_BYTES) begin
        // drop the overflowing byte and start over
        push_end(hafr_pkg::ST_OVERFLOW);
        restart_frame();
      end else begin
        fcs_acc = fcs16_next(fcs_acc, b);
        case (frame_len)
          0: hdr_match = (b == want_address);
          1: hdr_match = hdr_match && (b == want_control);
          2: proto_acc = {b, 8'h00};
          3: proto_acc[7:0] = b;
          default: ;
        endcase
        if (frame_len >= hafr_pkg::HEADER_BYTES) begin
          r.kind           = hafr_pkg::KIND_PAYLOAD;
          r.payload_byte   = lag[0];
          r.protocol_id    = 16'h0000;
          r.frame_status   = hafr_pkg::ST_GOOD;
          r.payload_length = 12'h000;
          add_expect(r);
        end
        lag[0]    = lag[1];
        lag[1]    = b;
        frame_len = frame_len + 1;
      end
    end
  endtask

  // escape what must be escaped, and now and then a byte that need not be
  task automatic queue_data(input logic [7:0] b);
    logic must, may;
    must = (b == hafr_pkg::FLAG_BYTE) || (b == hafr_pkg::ESC_BYTE);
    may  = ((b ^ hafr_pkg::ESC_XOR) != hafr_pkg::FLAG_BYTE) &&
           ((b ^ hafr_pkg::ESC_XOR) != hafr_pkg::ESC_BYTE) &&
           ($urandom_range(7) == 0);
    if (must || may) begin
      add_line(hafr_pkg::ESC_BYTE);
      add_line(b ^ hafr_pkg::ESC_XOR);
    end else begin
      add_line(b);
    end
  endtask

  // append the FCS to frame_body, optionally corrupt one bit, and send it
  task automatic queue_frame(input bit corrupt);
    logic [15:0] fcs;
    int          pick;
    fcs = hafr_pkg::CHECK_INIT;
    foreach (frame_body[i]) fcs = fcs16_next(fcs, frame_body[i]);
    fcs = ~fcs;
    add_body(fcs[7:0]);
    add_body(fcs[15:8]);
    if (corrupt) begin
      pick = $urandom_range(frame_body.size() - 1);
      frame_body[pick] = frame_body[pick] ^ (8'h01 << $urandom_range(7));
    end
    if ($urandom_range(1) == 0) add_line(hafr_pkg::FLAG_BYTE);
    foreach (frame_body[i]) queue_data(frame_body[i]);
    add_line(hafr_pkg::FLAG_BYTE);
    frame_body.delete();
  endtask

  task automatic queue_random_mix(input int count);
    int start, pick, n;
    start = line_q.size();
    while (line_q.size() - start < count) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        add_body(($urandom_range(9) != 0) ? want_address : 8'($urandom_range(255)));
        add_body(($urandom_range(9) != 0) ? want_control : 8'($urandom_range(255)));
        repeat (2 + $urandom_range(24)) add_body(8'($urandom_range(255)));
        queue_frame($urandom_range(9) == 0);
      end else if (pick < 70) begin
        repeat (1 + $urandom_range(2)) add_body(8'($urandom_range(255)));
        queue_frame(1'b0);
      end else if (pick < 80) begin
        repeat (1 + $urandom_range(9)) queue_data(8'($urandom_range(255)));
        add_line(hafr_pkg::FLAG_BYTE);
      end else if (pick < 92) begin
        repeat (1 + $urandom_range(7)) begin
          n = $urandom_range(3);
          add_line(n == 0 ? hafr_pkg::FLAG_BYTE :
                   n == 1 ? hafr_pkg::ESC_BYTE : 8'($urandom_range(255)));
        end
      end else begin
        // double escape, then an escape cut short by a flag
        add_line(hafr_pkg::ESC_BYTE);
        add_line(hafr_pkg::ESC_BYTE);
        add_line(8'($urandom_range(255)));
        add_line(hafr_pkg::ESC_BYTE);
        add_line(hafr_pkg::FLAG_BYTE);
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (line_q.size() != 0 || in_tvalid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_config(input logic [7:0] address, input logic [7:0] control);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= hafr_pkg::CFG_ADDRESS;
    cfg_data <= address;
    @(posedge clk);
    cfg_addr <= hafr_pkg::CFG_CONTROL;
    cfg_data <= control;
    @(posedge clk);
    cfg_we <= 1'b0;
    want_address = address;
    want_control = control;
    @(negedge clk);
  endtask

  // driver: offer queued line bytes, predict on acceptance
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) deframe_byte(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (line_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tdata  <= line_q.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result item with the oldest expectation
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got_count++;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("unexpected item: kind %0d tdata %h", out_tuser, out_tdata);
        end else begin
          oldest_result = expected_results.pop_front();
          if (out_tuser !== oldest_result.kind ||
              out_tdata[7:0] !== oldest_result.payload_byte ||
              out_tdata[23:8] !== oldest_result.protocol_id ||
              out_tdata[26:24] !== oldest_result.frame_status ||
              out_tdata[38:27] !== oldest_result.payload_length) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("item mismatch: want kind %0d byte %h proto %h status %0d len %0d",
                       oldest_result.kind, oldest_result.payload_byte,
                       oldest_result.protocol_id, oldest_result.frame_status,
                       oldest_result.payload_length);
              $display("               got kind %0d byte %h proto %h status %0d len %0d",
                       out_tuser, out_tdata[7:0], out_tdata[23:8], out_tdata[26:24],
                       out_tdata[38:27]);
            end
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && got_count == 100) begin
        // hold off long enough for the block to back up its input
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty frame
    add_line(hafr_pkg::FLAG_BYTE);
    add_line(hafr_pkg::FLAG_BYTE);
    // good frame with no payload
    add_body(8'hFF);
    add_body(8'h03);
    add_body(8'hC0);
    add_body(8'h21);
    queue_frame(1'b0);
    // too short, protocol only partly captured
    add_body(8'hFF);
    queue_frame(1'b0);
    // bad header carrying extreme payload bytes
    add_body(8'h00);
    add_body(8'h03);
    add_body(8'h00);
    add_body(8'h21);
    add_body(8'hFF);
    add_body(8'h00);
    queue_frame(1'b0);
    // escape held over an escape, then an escape cut off by a flag
    add_line(hafr_pkg::ESC_BYTE);
    add_line(hafr_pkg::ESC_BYTE);
    add_line(8'h5E);
    add_line(hafr_pkg::ESC_BYTE);
    add_line(hafr_pkg::FLAG_BYTE);
    wait_drained();

    write_config(8'h00, 8'hFF);
    queue_random_mix(650);
    wait_drained();

    write_config(8'h7E, 8'h7D);
    send_idle_pct = 79;
    recv_idle_pct = 20;
    queue_random_mix(325);
    wait_drained();
    queue_random_mix(325);
    wait_drained();

    write_config(8'hFF, 8'h03);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_mix(650);
    // one frame past the length limit
    add_line(hafr_pkg::FLAG_BYTE);
    repeat (MAX_BYTES + 4) queue_data(8'($urandom_range(255)));
    add_line(hafr_pkg::FLAG_BYTE);
    queue_random_mix(50);
    wait_drained();

    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
